// ===== rtl/cqp_pkg.sv =====
package cqp_pkg;

    localparam int ANGLE_W        = 32;
    localparam int ANGLE_FRAC_DEF = 16;
    localparam int OUT_FRAC_DEF   = 16;

    // internal fixed-point formats
    localparam int WFRAC = 32;   // reduced angle, Q.32
    localparam int PFRAC = 30;   // polynomial, Q.30

    // two pi and pi/2, rounded to nearest in Q3.32
    localparam int DW = 35;
    localparam logic [DW-1:0] TAU_Q32   = 35'h6487ED511;
    localparam logic [DW-1:0] PIO2_Q32  = 35'h1921FB544;
    localparam logic [DW-1:0] PIO2_X2   = DW'(2 * PIO2_Q32);
    localparam logic [DW-1:0] PIO2_X3   = DW'(3 * PIO2_Q32);
    localparam logic [DW-1:0] PIO2_X4   = DW'(4 * PIO2_Q32);

    // two pi split for the partial products of k * two pi
    localparam int DLW = 18;
    localparam int DHW = DW - DLW;

    // remainder estimate lies below twice two pi
    localparam int RRW = DW + 1;

    localparam int XW   = 31;    // reduced magnitude, Q.30
    localparam int X2W  = 32;    // its square, Q.30
    localparam int ACCW = 32;    // Horner accumulator
    localparam int PRW  = 34;    // shifted Horner product

    // coefficients in Q.30, highest power first
    localparam int NCOEF = 5;
    localparam logic signed [ACCW-1:0] POLY_COEF [NCOEF] = '{
        32'sd25491,
        -32'sd1489753,
        32'sd44738374,
        -32'sd536870740,
        32'sd1073741817
    };

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic          neg;
        logic [XW-1:0] x30;
    } t_red;

endpackage

// ===== rtl/cqp_front.sv =====
module cqp_front
    import cqp_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [ANGLE_W-1:0] i_angle,
    input  logic               i_full,
    output logic               o_push,
    output t_red               o_item
);

    localparam int SH = WFRAC - ANGLE_FRAC_BITS;
    // k estimate = floor(mag * RECIP / 2^32), never more than one below k
    localparam logic [63:0] RECIP = (64'd1 << (32 + SH)) / 64'(TAU_Q32);
    localparam int RW = $clog2(RECIP + 64'd1);
    localparam int KW = $clog2(((64'd1 << (31 + SH)) / 64'(TAU_Q32)) + 64'd1);
    localparam logic [RW-1:0]  RECIP_R = RW'(RECIP);
    localparam logic [DLW-1:0] D_LO    = TAU_Q32[DLW-1:0];
    localparam logic [DHW-1:0] D_HI    = TAU_Q32[DW-1:DLW];

    logic en;
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    logic [31:0]       r_mag0, r_mag1, r_mag2;
    logic [KW-1:0]     r_k1;
    logic [KW+DLW-1:0] r_plo2;
    logic [KW+DHW-1:0] r_phi2;
    logic [RRW-1:0]    r_rest3;
    logic [DW-1:0]     r_r4, r_r5;
    logic [1:0]        r_q5;
    t_red              r_item6;

    logic [31:0]       n_mag;
    logic [31+RW:0]    kprod;
    logic [KW-1:0]     n_k;
    logic [31+SH:0]    a_ext;
    logic [RRW-1:0]    ksub;
    logic [RRW-1:0]    n_rest;
    logic [DW-1:0]     n_r;
    logic [1:0]        n_q;
    logic [DW-1:0]     sub_a, sub_b, xm;
    t_red              n_item;

    assign en     = !(r_v6 && i_full);
    assign o_busy = !en;
    assign o_push = r_v6 && !i_full;
    assign o_item = r_item6;

    always_comb begin
        n_mag = i_angle[ANGLE_W-1] ? 32'(~i_angle + 32'd1) : i_angle;

        kprod = r_mag0 * RECIP_R;
        n_k   = kprod[32 +: KW];

        a_ext  = {r_mag2, {SH{1'b0}}};
        ksub   = RRW'({r_phi2, {DLW{1'b0}}}) + RRW'(r_plo2);
        n_rest = a_ext[RRW-1:0] - ksub;

        n_r = (r_rest3 >= RRW'(TAU_Q32)) ? DW'(r_rest3 - RRW'(TAU_Q32)) : DW'(r_rest3);

        // quadrant count saturates at 3 just below two pi
        if (r_r4 >= PIO2_X3) begin
            n_q = 2'd3;
        end else if (r_r4 >= PIO2_X2) begin
            n_q = 2'd2;
        end else if (r_r4 >= PIO2_Q32) begin
            n_q = 2'd1;
        end else begin
            n_q = 2'd0;
        end

        // odd quadrants: distance to the next multiple of pi/2; even: distance from the one below
        case (r_q5)
            2'd0: begin
                sub_a = r_r5;
                sub_b = '0;
            end
            2'd1: begin
                sub_a = PIO2_X2;
                sub_b = r_r5;
            end
            2'd2: begin
                sub_a = r_r5;
                sub_b = PIO2_X2;
            end
            2'd3: begin
                sub_a = PIO2_X4;
                sub_b = r_r5;
            end
            default: begin
                sub_a = r_r5;
                sub_b = '0;
            end
        endcase
        xm         = sub_a - sub_b;
        n_item.neg = r_q5[0] ^ r_q5[1];
        n_item.x30 = xm[(WFRAC-PFRAC) +: XW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag0  <= n_mag;
            r_mag1  <= r_mag0;
            r_k1    <= n_k;
            r_mag2  <= r_mag1;
            r_plo2  <= r_k1 * D_LO;
            r_phi2  <= r_k1 * D_HI;
            r_rest3 <= n_rest;
            r_r4    <= n_r;
            r_r5    <= r_r4;
            r_q5    <= n_q;
            r_item6 <= n_item;
        end
    end

endmodule

// ===== rtl/cqp_queue.sv =====
module cqp_queue
    import cqp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_red i_item,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_red o_item
);

    t_red           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt;
    logic           do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QAW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= QAW'(r_rd + 1'b1);
            end
            r_cnt <= QCW'(r_cnt + QCW'(i_push) - QCW'(do_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== rtl/cqp_back.sv =====
module cqp_back
    import cqp_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_red                     i_item,
    output logic                     o_valid,
    output logic [OUT_FRAC_BITS+1:0] o_cosine
);

    localparam int OW    = OUT_FRAC_BITS + 2;
    localparam int S     = PFRAC - OUT_FRAC_BITS;
    localparam int NSTEP = NCOEF - 1;
    localparam logic signed [PRW-1:0] HALF = (PRW'(1) <<< S) >>> 1;
    localparam logic signed [PRW-1:0] LIM  = PRW'(1) <<< OUT_FRAC_BITS;

    // square stage
    logic           r_vs;
    logic           r_negs;
    logic [X2W-1:0] r_x2s;
    logic [2*XW-1:0] sq;

    // Horner steps: multiply stage then add stage
    logic                   r_vm   [NSTEP];
    logic                   r_va   [NSTEP];
    logic                   r_negm [NSTEP];
    logic                   r_nega [NSTEP];
    logic [X2W-1:0]         r_x2m  [NSTEP];
    logic [X2W-1:0]         r_x2a  [NSTEP-1];
    logic signed [PRW-1:0]  r_prod [NSTEP];
    logic signed [ACCW-1:0] r_acc  [NSTEP];

    // sign and output stages
    logic                  r_vn, r_vo;
    logic signed [PRW-1:0] r_y;
    logic [OW-1:0]         r_cos;
    logic signed [PRW-1:0] n_y, yr, res;
    logic [OW-1:0]         n_cos;

    assign sq = i_item.x30 * i_item.x30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else begin
            r_vs <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_negs <= i_item.neg;
        r_x2s  <= sq[PFRAC +: X2W];
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        logic                   v_in;
        logic                   neg_in;
        logic [X2W-1:0]         x2_in;
        logic signed [ACCW-1:0] acc_in;
        logic signed [ACCW+X2W:0] prod_full;

        if (i == 0) begin : g_first
            assign v_in   = r_vs;
            assign neg_in = r_negs;
            assign x2_in  = r_x2s;
            assign acc_in = POLY_COEF[0];
        end else begin : g_next
            assign v_in   = r_va[i-1];
            assign neg_in = r_nega[i-1];
            assign x2_in  = r_x2a[i-1];
            assign acc_in = r_acc[i-1];
        end

        assign prod_full = acc_in * $signed({1'b0, x2_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vm[i] <= 1'b0;
                r_va[i] <= 1'b0;
            end else begin
                r_vm[i] <= v_in;
                r_va[i] <= r_vm[i];
            end
        end

        // floor shift by PFRAC: arithmetic part-select of the signed product
        always_ff @(posedge i_clk) begin
            r_negm[i] <= neg_in;
            r_x2m[i]  <= x2_in;
            r_prod[i] <= prod_full[PFRAC +: PRW];
            r_nega[i] <= r_negm[i];
            r_acc[i]  <= ACCW'(r_prod[i] + PRW'(POLY_COEF[i+1]));
        end

        if (i < NSTEP - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_x2a[i] <= r_x2m[i];
            end
        end
    end

    always_comb begin
        n_y = r_nega[NSTEP-1] ? -PRW'(r_acc[NSTEP-1]) : PRW'(r_acc[NSTEP-1]);

        yr  = r_y + HALF;
        res = yr >>> S;
        if (res > LIM) begin
            n_cos = OW'(LIM);
        end else if (res < -LIM) begin
            n_cos = OW'(-LIM);
        end else begin
            n_cos = OW'(res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_vn <= r_va[NSTEP-1];
            r_vo <= r_vn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y   <= n_y;
        r_cos <= n_cos;
    end

    assign o_valid  = r_vo;
    assign o_cosine = r_cos;

endmodule

// ===== rtl/cosine_quadrant_polynomial.sv =====
// Channel   Ports                  Direction  Taken when
// request   start, busy, i_angle   in         start && !busy at a rising edge
// result    o_valid, o_cosine      out        o_valid high, one cycle, no hold-off
//
// One request per clock while busy is low. Between a request and its result lie
// range reduction (magnitude, k estimate, k times two pi, remainder, fixup,
// quadrant, fold), the queue, and the polynomial (square, four
// multiply/add Horner steps, sign, round and saturate).
// Reset (synchronous, active low) empties the pipelines and the queue.
// busy rises only if the queue between the two halves is full.
module cosine_quadrant_polynomial
    import cqp_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [ANGLE_W-1:0]       i_angle,
    output logic                            o_valid,
    output logic signed [OUT_FRAC_BITS+1:0] o_cosine
);

    logic q_full;
    logic q_push;
    logic q_valid;
    t_red f_item;
    t_red q_item;

    cqp_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_angle (i_angle),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_item  (f_item)
    );

    cqp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cqp_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_valid  (o_valid),
        .o_cosine (o_cosine)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import cqp_pkg::*;

    localparam int OUT_W        = OUT_FRAC_DEF + 2;
    localparam int RND_SHIFT    = 30 - OUT_FRAC_DEF;
    localparam int LATENCY      = 18;
    localparam int RANDOM_ITEMS = 1725;
    localparam int QUIET_TAIL   = 200;
    localparam int LIMIT_CYCLES = 200000;

    // two pi and pi/2 in Q3.32, rounded to nearest
    localparam longint unsigned TWO_PI_Q32  = 64'h6487ED511;
    localparam longint unsigned HALF_PI_Q32 = 64'h1921FB544;

    // Horner coefficients in Q.30, x^8 term first
    localparam longint C_X8 = 25491;
    localparam longint C_X6 = -1489753;
    localparam longint C_X4 = 44738374;
    localparam longint C_X2 = -536870740;
    localparam longint C_X0 = 1073741817;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [OUT_W-1:0]   cosine;
    } cos_due_t;

    class cosine_scoreboard;
        cos_due_t cos_due[$];
        int       mismatches;
        int       angles_taken;
        int       results_seen;

        function new();
            mismatches   = 0;
            angles_taken = 0;
            results_seen = 0;
        endfunction

        function automatic logic signed [OUT_W-1:0] cosine_of(logic signed [ANGLE_W-1:0] a);
            longint unsigned mag, wide, k, resid, quad, m, xm, x30, xsq;
            longint          x2s, acc, y;
            mag   = a[ANGLE_W-1] ? (64'h1_0000_0000 - {32'b0, a}) : {32'b0, a};
            wide  = mag << (32 - ANGLE_FRAC_DEF);
            k     = wide / TWO_PI_Q32;
            resid = wide - k * TWO_PI_Q32;
            quad  = resid / HALF_PI_Q32;
            // rounding of pi/2 can push the count to 4 just below two pi
            if (quad > 3)
                quad = 3;
            m   = resid - quad * HALF_PI_Q32;
            xm  = quad[0] ? (HALF_PI_Q32 - m) : m;
            x30 = xm >> 2;
            xsq = (x30 * x30) >> 30;
            x2s = longint'(xsq);
            acc = C_X8;
            acc = ((acc * x2s) >>> 30) + C_X6;
            acc = ((acc * x2s) >>> 30) + C_X4;
            acc = ((acc * x2s) >>> 30) + C_X2;
            acc = ((acc * x2s) >>> 30) + C_X0;
            y = (quad == 1 || quad == 2) ? -acc : acc;
            if (RND_SHIFT > 0)
                y = y + (longint'(1) << (RND_SHIFT - 1));
            y = y >>> RND_SHIFT;
            if (y > (longint'(1) << OUT_FRAC_DEF))
                y = longint'(1) << OUT_FRAC_DEF;
            if (y < -(longint'(1) << OUT_FRAC_DEF))
                y = -(longint'(1) << OUT_FRAC_DEF);
            return y[OUT_W-1:0];
        endfunction

        task report_mismatch(string what);
            $display("%0t ERROR: %s", $time, what);
            mismatches++;
        endtask

        function void note_angle(logic signed [ANGLE_W-1:0] a);
            cos_due_t e;
            e.angle  = a;
            e.cosine = cosine_of(a);
            cos_due.push_back(e);
            angles_taken++;
        endfunction

        task check_cosine(logic signed [OUT_W-1:0] got);
            cos_due_t e;
            if (cos_due.size() == 0) begin
                report_mismatch($sformatf("cosine %0d arrived with no request outstanding",
                                          got));
            end else begin
                e = cos_due.pop_front();
                results_seen++;
                if (got !== e.cosine)
                    report_mismatch($sformatf("angle %h: cosine %0d, expected %0d",
                                              e.angle, got, e.cosine));
            end
        endtask

        function int pending();
            return cos_due.size();
        endfunction
    endclass

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start   = 1'b0;
    logic signed [ANGLE_W-1:0]   i_angle = '0;
    logic                        busy;
    logic                        o_valid;
    logic signed [OUT_W-1:0]     o_cosine;
    int                          cycles  = 0;

    cosine_scoreboard sb = new();

    cosine_quadrant_polynomial dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_angle  (i_angle),
        .o_valid  (o_valid),
        .o_cosine (o_cosine)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_angle(i_angle);
            if (o_valid)
                sb.check_cosine(o_cosine);
        end
    end

    task send_angle(logic signed [ANGLE_W-1:0] a);
        @(negedge i_clk);
        start   <= 1'b1;
        i_angle <= a;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task hold_start_low(int n);
        @(negedge i_clk);
        start   <= 1'b0;
        i_angle <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    task wait_results_in();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // magnitude in LSBs, optionally negated; kept inside the 32-bit range
    function automatic logic signed [ANGLE_W-1:0] signed_angle(longint v, bit neg);
        if (v < 0)
            v = 0;
        if (neg) begin
            if (v > 64'sh8000_0000)
                v = 64'sh8000_0000;
            v = -v;
        end else if (v > 64'sh7FFF_FFFF) begin
            v = 64'sh7FFF_FFFF;
        end
        return v[ANGLE_W-1:0];
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        longint base;
        bit     neg;
        neg = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return signed_angle($urandom_range(0, 823550), neg);
            2: begin
                // close to a multiple of pi/2
                base = longint'(($urandom_range(0, 20860) * HALF_PI_Q32) >> 16);
                return signed_angle(base + $urandom_range(0, 6) - 3, neg);
            end
            default: begin
                // close to a multiple of two pi, mostly just below it
                base = longint'(($urandom_range(1, 5215) * TWO_PI_Q32) >> 16);
                return signed_angle(base + $urandom_range(0, 4) - 3, neg);
            end
        endcase
    endfunction

    initial begin
        logic signed [ANGLE_W-1:0] directed[$];
        int                        j;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{32'sd0, 32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'sd102943, 32'sd102944, -32'sd102944, 32'sd205887, 32'sd205888,
                     32'sd308831, 32'sd308832, 32'sd411774, 32'sd411775, -32'sd411775,
                     32'sd65536, 32'h4000_0000, 32'hC000_0000, 32'h5555_5555,
                     32'hAAAA_AAAA};
        // directed edges and quadrant boundaries, then residues just below multiples of two pi
        foreach (directed[i])
            send_angle(directed[i]);
        for (j = 1; j <= 5000; j = j * 70 + 1)
            send_angle(signed_angle(longint'((j * TWO_PI_Q32) >> 16), j[1]));
        wait_results_in();

        for (j = 0; j < RANDOM_ITEMS; j++) begin
            if (j < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                hold_start_low($urandom_range(1, 5));
            if (j == RANDOM_ITEMS / 2)
                wait_results_in();
            send_angle(pick_angle());
        end

        wait_results_in();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d cosine results never arrived", sb.pending()));

        $display("Sent %0d angles (edges, quadrant boundaries, full range); checked %0d cosines.",
                 sb.angles_taken, sb.results_seen);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
